[design/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, codes and the reciprocal table for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

    localparam int CFG_DW = 13;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int RECIP_SHIFT = 20;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blur_red;
        logic [7:0] blur_green;
        logic [7:0] blur_blue;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic read;
        logic push;
        logic sum;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic drain_ok;
        logic pend_full;
        logic more_push;
        logic out_free;
        logic is_pixel;
    } t_dp_status;

    // ceil(2^20 / (2*count)); exact floor division for numerators below 2^13
    function automatic logic [19:0] f_recip(input logic [3:0] count);
        logic [19:0] k;
        case (count)
            4'd1:    k = 20'd524288;
            4'd2:    k = 20'd262144;
            4'd3:    k = 20'd174763;
            4'd4:    k = 20'd131072;
            4'd6:    k = 20'd87382;
            4'd9:    k = 20'd58255;
            default: k = 20'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[design/rbb_ctrl.sv]
// ----------------------------------------------------------------------------
// rbb_ctrl
// Sequencer: read line buffers, push a window column, sum, divide and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_in_op,
    output logic                     o_in_ready,
    input  wire rbb_pkg::t_dp_status i_status,
    output rbb_pkg::t_dp_cmd         o_cmd
);
    import rbb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_in_op == OP_PIXEL || i_status.drain_ok) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_status.is_pixel) begin
                    n_state = i_status.pend_full ? S_SUM : S_IDLE;
                end else begin
                    // one-row frames need a second phantom column
                    n_state = i_status.more_push ? S_READ : S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/rbb_datapath.sv]
// ----------------------------------------------------------------------------
// rbb_datapath
// Line buffers, 3x3 window, stream counters, neighborhood sum and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_datapath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_index,
    input  wire [rbb_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire rbb_pkg::t_in_item    i_in_data,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output rbb_pkg::t_out_item        o_out_data,
    input  wire rbb_pkg::t_dp_cmd     i_cmd,
    output rbb_pkg::t_dp_status       o_status
);
    import rbb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH + 3);
    localparam int WIDTH_RST  = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
    localparam int HEIGHT_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

    logic [23:0] r_mem_up  [MAX_WIDTH];
    logic [23:0] r_mem_mid [MAX_WIDTH];
    logic [23:0] r_rd_up;
    logic [23:0] r_rd_mid;
    logic [23:0] r_win [9];

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_ph_col;
    logic [PW-1:0] r_pending;
    logic [PW-1:0] r_phantoms;
    logic          r_is_pix;
    logic [23:0]   r_pix;

    logic [11:0]   r_sum [3];
    logic [3:0]    r_count;
    logic          r_last;

    logic          r_out_valid;
    t_out_item     r_out;

    logic [CW-1:0] rd_addr;
    logic [23:0]   stack [3];
    logic          in_col_end;
    logic          in_row_end;
    logic          out_col_end;
    logic          out_row_end;
    logic          top_ok;
    logic          bot_ok;
    logic          left_ok;
    logic          right_ok;
    logic [1:0]    n_rows;
    logic [1:0]    n_cols;
    logic [11:0]   sum_c [3];
    logic [19:0]   recip;
    logic [12:0]   numer [3];
    logic [32:0]   prod [3];
    logic [11:0]   cfg_w;
    logic [12:0]   cfg_h;

    assign rd_addr = r_is_pix ? r_in_col : r_ph_col;
    assign stack[0] = r_rd_up;
    assign stack[1] = r_rd_mid;
    assign stack[2] = r_is_pix ? r_pix : 24'd0;

    assign in_col_end  = 32'(r_in_col) + 32'd1 >= 32'(r_width);
    assign in_row_end  = 32'(r_in_row) + 32'd1 >= 32'(r_height);
    assign out_col_end = 32'(r_out_col) + 32'd1 >= 32'(r_width);
    assign out_row_end = 32'(r_out_row) + 32'd1 >= 32'(r_height);

    assign top_ok   = r_out_row != '0;
    assign bot_ok   = !out_row_end;
    assign left_ok  = r_out_col != '0;
    assign right_ok = !out_col_end;
    assign n_rows   = 2'd1 + {1'b0, top_ok} + {1'b0, bot_ok};
    assign n_cols   = 2'd1 + {1'b0, left_ok} + {1'b0, right_ok};

    assign cfg_w = i_cfg_wdata[11:0];
    assign cfg_h = i_cfg_wdata[12:0];

    always_comb begin
        logic ok;
        for (int ch = 0; ch < 3; ch++) begin
            sum_c[ch] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ok = (r != 0 || top_ok) && (r != 2 || bot_ok) &&
                     (c != 0 || left_ok) && (c != 2 || right_ok);
                if (ok) begin
                    sum_c[0] = sum_c[0] + {4'd0, r_win[r*3+c][23:16]};
                    sum_c[1] = sum_c[1] + {4'd0, r_win[r*3+c][15:8]};
                    sum_c[2] = sum_c[2] + {4'd0, r_win[r*3+c][7:0]};
                end
            end
        end
    end

    // rounded mean: floor((2*sum + count) / (2*count)) by reciprocal
    assign recip = f_recip(r_count);
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            numer[ch] = {r_sum[ch], 1'b0} + {9'd0, r_count};
            prod[ch]  = 33'(numer[ch]) * 33'(recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_up  <= r_mem_up[rd_addr];
            r_rd_mid <= r_mem_mid[rd_addr];
        end
        if (i_cmd.push && r_is_pix) begin
            r_mem_up[r_in_col]  <= r_rd_mid;
            r_mem_mid[r_in_col] <= r_pix;
        end
        if (i_cmd.take) begin
            r_pix <= {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
        if (i_cmd.sum) begin
            r_sum   <= sum_c;
            r_count <= {2'b00, n_rows} * {2'b00, n_cols};
            r_last  <= out_row_end && out_col_end;
        end
        if (i_cmd.emit) begin
            r_out.blur_red   <= prod[0][RECIP_SHIFT+7:RECIP_SHIFT];
            r_out.blur_green <= prod[1][RECIP_SHIFT+7:RECIP_SHIFT];
            r_out.blur_blue  <= prod[2][RECIP_SHIFT+7:RECIP_SHIFT];
            r_out.frame_end  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(WIDTH_RST);
            r_height   <= HW'(HEIGHT_RST);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_ph_col   <= '0;
            r_pending  <= '0;
            r_phantoms <= '0;
            r_is_pix   <= 1'b1;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH: begin
                    if (cfg_w == '0) begin
                        r_width <= WW'(1);
                    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(cfg_w);
                    end
                end
                CFG_IDX_HEIGHT: begin
                    if (cfg_h == '0) begin
                        r_height <= HW'(1);
                    end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
                        r_height <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height <= HW'(cfg_h);
                    end
                end
            endcase
            // any register write restarts the stream
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_ph_col   <= '0;
            r_pending  <= '0;
            r_phantoms <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cmd.take) begin
                r_is_pix <= (i_in_data.op == OP_PIXEL);
                // pixel after drain items drops what is pending
                if (i_in_data.op == OP_PIXEL && r_phantoms != '0) begin
                    r_pending  <= '0;
                    r_phantoms <= '0;
                    r_ph_col   <= '0;
                    r_out_col  <= r_in_col;
                    r_out_row  <= r_in_row;
                end
            end
            if (i_cmd.push) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]   <= r_win[r*3+1];
                    r_win[r*3+1] <= r_win[r*3+2];
                    r_win[r*3+2] <= stack[r];
                end
                if (r_is_pix) begin
                    r_pending <= r_pending + PW'(1);
                    if (in_col_end) begin
                        r_in_col <= '0;
                        r_in_row <= in_row_end ? '0 : r_in_row + RW'(1);
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                end else begin
                    r_phantoms <= r_phantoms + PW'(1);
                    r_ph_col   <= (32'(r_ph_col) + 32'd1 >= 32'(r_width)) ?
                                  '0 : r_ph_col + CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_pending <= r_pending - PW'(1);
                if (!r_is_pix && r_pending == PW'(1)) begin
                    r_phantoms <= '0;
                    r_ph_col   <= '0;
                end
                if (out_col_end) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_end ? '0 : r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    assign o_status.drain_ok  = r_pending != '0 && r_in_col == '0 && r_in_row == '0;
    assign o_status.pend_full = 32'(r_pending) >= 32'(r_width) + 32'd1;
    assign o_status.more_push = 32'(r_pending) + 32'(r_phantoms) + 32'd1 <
                                32'(r_width) + 32'd2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.is_pixel  = r_is_pix;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[design/rgb_box_blur_3x3.sv]
// A pixel that completes no window is accepted, then read from the line buffers and pushed.
// A pixel that completes a window goes on to the sum and divide stages after the push.
// A drain that emits does the same, with a second read and push for a one-row frame.
// An ignored drain is only accepted; the line buffer read is registered.
// Output sits in a register, so the next item is accepted while a result waits.
// Synchronous active-low reset clears counters and window; line buffers are not cleared.
`default_nettype none

module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_index,
    input  wire [rbb_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire rbb_pkg::t_in_item    i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output rbb_pkg::t_out_item        o_out_data
);
    import rbb_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    rbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

[verif/rbb_checker.sv]
// ----------------------------------------------------------------------------
// rbb_checker
// Watches the config port and both channels of the 3x3 RGB box blur, predicts
// every blurred pixel from the accepted input stream and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rbb_checker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_index,
    input  wire [rbb_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire                       i_in_valid,
    input  wire                       i_in_ready,
    input  rbb_pkg::t_in_item         i_in_data,
    input  wire                       i_out_valid,
    input  wire                       i_out_ready,
    input  rbb_pkg::t_out_item        i_out_data,
    output int                        o_fail_count,
    output int                        o_blur_pending
);
    import rbb_pkg::*;

    localparam int LINE_MAX = 2048;
    localparam int ROWS_MAX = 4096;

    logic [23:0] upper_buf [LINE_MAX];
    logic [23:0] middle_buf [LINE_MAX];
    logic [23:0] win [9];
    int          wid, hgt;
    int          in_col, in_row, out_col, out_row;
    int          held, ghosts;
    t_out_item   blur_q [$];

    assign o_blur_pending = blur_q.size();

    task automatic restart();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        held = 0; ghosts = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
    endtask

    task automatic shift_column(input int col, input logic [23:0] bottom, input bit store);
        logic [23:0] stack [3];
        int c;
        c = (col >= LINE_MAX) ? LINE_MAX - 1 : col;
        stack[0] = upper_buf[c];
        stack[1] = middle_buf[c];
        stack[2] = bottom;
        if (store) begin
            upper_buf[c] = middle_buf[c];
            middle_buf[c] = bottom;
        end
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = stack[r];
        end
    endtask

    task automatic blur_window();
        int sr, sg, sb, cnt;
        t_out_item o;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                if (!((dr == 0 && out_row < 1) || (dr == 2 && out_row + 1 >= hgt) ||
                      (dc == 0 && out_col < 1) || (dc == 2 && out_col + 1 >= wid))) begin
                    sr += win[dr*3+dc][23:16];
                    sg += win[dr*3+dc][15:8];
                    sb += win[dr*3+dc][7:0];
                    cnt++;
                end
            end
        end
        o.blur_red   = 8'((2*sr + cnt) / (2*cnt));
        o.blur_green = 8'((2*sg + cnt) / (2*cnt));
        o.blur_blue  = 8'((2*sb + cnt) / (2*cnt));
        o.frame_end  = (out_row + 1 >= hgt) && (out_col + 1 >= wid);
        blur_q.push_back(o);
        out_col++;
        if (out_col >= wid) begin
            out_col = 0;
            out_row++;
            if (out_row >= hgt) out_row = 0;
        end
    endtask

    task automatic take_item(input t_in_item it);
        if (it.op == OP_PIXEL) begin
            if (ghosts != 0) begin
                held = 0; ghosts = 0;
                out_row = in_row; out_col = in_col;
            end
            shift_column(in_col, {it.red, it.green, it.blue}, 1'b1);
            in_col++;
            if (in_col >= wid) begin
                in_col = 0;
                in_row++;
                if (in_row >= hgt) in_row = 0;
            end
            held++;
            if (held >= wid + 2) begin
                blur_window();
                held--;
            end
        end else if (held != 0 && in_row == 0 && in_col == 0) begin
            do begin
                shift_column(ghosts % wid, 24'd0, 1'b0);
                ghosts++;
            end while (held + ghosts < wid + 2);
            blur_window();
            held--;
            if (held == 0) ghosts = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_MAX; i++) begin
                upper_buf[i] = '0;
                middle_buf[i] = '0;
            end
            wid = 640; hgt = 480;
            restart();
            blur_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_WIDTH) begin
                    wid = i_cfg_wdata[11:0];
                    if (wid == 0) wid = 1;
                    if (wid > LINE_MAX) wid = LINE_MAX;
                end else begin
                    hgt = i_cfg_wdata[12:0];
                    if (hgt == 0) hgt = 1;
                    if (hgt > ROWS_MAX) hgt = ROWS_MAX;
                end
                restart();
            end
            if (i_out_valid && i_out_ready) begin
                if (blur_q.size() == 0) begin
                    $display("%0t: unexpected output, actual %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    t_out_item e;
                    e = blur_q.pop_front();
                    if (e.blur_red !== i_out_data.blur_red ||
                        e.blur_green !== i_out_data.blur_green ||
                        e.blur_blue !== i_out_data.blur_blue ||
                        e.frame_end !== i_out_data.frame_end) begin
                        $display("%0t: mismatch expected r%h g%h b%h end%b actual r%h g%h b%h end%b",
                                 $time, e.blur_red, e.blur_green, e.blur_blue, e.frame_end,
                                 i_out_data.blur_red, i_out_data.blur_green,
                                 i_out_data.blur_blue, i_out_data.frame_end);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) take_item(i_in_data);
        end
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the 3x3 RGB box blur: directed frame shapes and corner values,
// then random frames with drains, noise and stalls; the checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import rbb_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_IDX_WIDTH;
    logic [CFG_DW-1:0]   cfg_wdata = '0;
    logic                in_valid = 1'b0;
    t_in_item            in_data = '0;
    logic                out_ready = 1'b0;
    logic                in_ready, out_valid;
    t_out_item           out_data;
    int                  fail_count, blur_pending;
    int                  burst_left = 0;
    int                  items_sent = 0;
    bit                  hold_req = 1'b0;

    always #6 i_clk = ~i_clk;

    rgb_box_blur_3x3 u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    rbb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_blur_pending(blur_pending)
    );

    // receiver: stall pattern changes per segment, plus one long hold-off
    initial begin
        int seg, mode, hold_cnt;
        bit hold_done;
        seg = 0; mode = 0; hold_cnt = 0; hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(30, 200);
                    mode = $urandom_range(0, 3);
                end
                seg--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 0);
                    2: out_ready <= ($urandom_range(0, 4) != 0);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item pix(input logic [7:0] r, g, b);
        t_in_item it;
        it.op = OP_PIXEL; it.red = r; it.green = g; it.blue = b;
        return it;
    endfunction

    function automatic t_in_item drain_item();
        t_in_item it;
        it.op = OP_DRAIN;
        it.red = 8'($urandom); it.green = 8'($urandom); it.blue = 8'($urandom);
        return it;
    endfunction

    task automatic offer(input t_in_item it);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
    endtask

    // let every expected transfer arrive, then cover items that emit nothing
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (blur_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_IDX_WIDTH, CFG_DW'(w));
            write_reg(CFG_IDX_HEIGHT, CFG_DW'(h));
        end else begin
            write_reg(CFG_IDX_HEIGHT, CFG_DW'(h));
            write_reg(CFG_IDX_WIDTH, CFG_DW'(w));
        end
    endtask

    task automatic send_frame(input int n, input int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct) offer(drain_item());
            offer(pix(chan(), chan(), chan()));
        end
    endtask

    initial begin
        int w, h, nf, cut;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single pixel frame at both extremes, then a drain with nothing left
        set_frame(1, 1);
        offer(pix(8'hff, 8'hff, 8'hff));
        offer(drain_item());
        offer(drain_item());
        offer(pix(8'h00, 8'h00, 8'h00));
        offer(drain_item());
        // zero registers clamp to one
        set_frame(0, 0);
        offer(pix(8'h80, 8'h7f, 8'h01));
        offer(drain_item());
        // one-row frame
        set_frame(3, 1);
        offer(pix(8'h00, 8'hff, 8'h00));
        offer(pix(8'hff, 8'h00, 8'hff));
        offer(pix(8'h55, 8'haa, 8'h01));
        repeat (3) offer(drain_item());
        // drain before frame complete, then pixel after drains
        set_frame(2, 2);
        offer(pix(8'hff, 8'h00, 8'h80));
        offer(drain_item());
        offer(pix(8'h00, 8'hff, 8'h7f));
        offer(pix(8'h12, 8'h34, 8'h56));
        offer(pix(8'hff, 8'hff, 8'hff));
        offer(drain_item());
        offer(pix(8'h01, 8'h02, 8'h03));

        // long receiver hold-off while the sender keeps going
        set_frame(30, 4);
        hold_req = 1'b1;
        send_frame(120, 0);
        repeat (32) offer(drain_item());

        // sender waits for all results before each new frame setting
        while (items_sent < 780) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(w, h);
            nf = $urandom_range(1, 3);
            case ($urandom_range(0, 9))
                0: begin
                    // broken frame: possibly cut short, drains ignored unless the frame is complete
                    cut = $urandom_range(1, w * h);
                    send_frame(cut, 10);
                    repeat ($urandom_range(1, 3)) offer(drain_item());
                end
                1: begin
                    // partial or full drain then a new frame
                    send_frame(w * h, 0);
                    repeat ($urandom_range(1, w + 1)) offer(drain_item());
                    send_frame(w * h, 0);
                    repeat (w + 3) offer(drain_item());
                end
                default: begin
                    send_frame(nf * w * h, 3);
                    repeat (w + 1 + $urandom_range(0, 2)) offer(drain_item());
                end
            endcase
        end

        // widest setting, width write clamps, only part of the first row
        set_frame(13'h1fff, 1);
        send_frame(60, 0);
        offer(drain_item());
        // tallest setting, only a partial frame
        set_frame(1, 13'h1fff);
        send_frame(10, 20);
        offer(drain_item());
        // restore defaults and run a little
        set_frame(640, 480);
        send_frame(40, 0);

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/rbb_pkg.sv
design/rbb_ctrl.sv
design/rbb_datapath.sv
design/rgb_box_blur_3x3.sv
verif/rbb_checker.sv
verif/testbench.sv
